// ===== design/wgm_pkg.sv =====
// Shared types, codes and the case-folding function of the glob matcher.
// No dependencies; every other file of the block imports this package.
package wgm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_STRING = 2'd2,
        OP_END    = 2'd3
    } t_op;

    localparam logic [1:0] MODE_ASCII = 2'd1;
    localparam logic [1:0] MODE_IRC   = 2'd2;

    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] QUERY_CHAR = 8'h3F;

    // Broadcast to every cell of the chain in the cycle of a transaction.
    typedef struct packed {
        logic       str_step;  // advance the position set by one string byte
        logic       app_wr;    // store the mask byte at the tail position
        logic       restart;   // back to position zero only
        logic       end_str;   // restart at end of string: skip over a leading star
        logic [7:0] ch;        // raw byte of the transaction
        logic [7:0] ch_fold;   // same byte after case folding
        logic [1:0] mode;      // case mode for folding stored mask bytes
    } t_cell_ctl;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic [1:0] mode);
        logic [7:0] r;
        r = c;
        if ((mode == MODE_ASCII || mode == MODE_IRC) && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        if (mode == MODE_IRC) begin
            case (c)
                8'h5B:   r = 8'h7B;
                8'h5D:   r = 8'h7D;
                8'h5C:   r = 8'h7C;
                8'h7E:   r = 8'h5E;
                default: r = r;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== design/wgm_if.sv =====
// Valid/ready channel interfaces of the glob matcher: request and response.
// Depends on wgm_pkg for the operation code type.
interface wgm_req_if;
    import wgm_pkg::*;
    logic       valid;
    logic       ready;
    t_op        operation;
    logic [7:0] ch;
    modport source (output valid, output operation, output ch, input ready);
    modport sink   (input valid, input operation, input ch, output ready);
endinterface

interface wgm_rsp_if;
    logic valid;
    logic ready;
    logic matched;
    logic mask_overflow;
    modport source (output valid, output matched, output mask_overflow, input ready);
    modport sink   (input valid, input matched, input mask_overflow, output ready);
endinterface

// ===== design/wgm_cell.sv =====
// One mask position of the glob matcher chain: stored mask byte and live bit.
// Depends on wgm_pkg for the control struct and the folding function.
module wgm_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wgm_pkg::t_cell_ctl i_ctl,
    input  logic [LEN_W-1:0]  i_len,
    input  logic              i_step,
    input  logic              i_fwd,
    output logic              o_step,
    output logic              o_fwd,
    output logic              o_live
);
    import wgm_pkg::*;

    localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

    logic [7:0] r_ch;
    logic [7:0] n_ch;
    logic       r_live;
    logic       n_live;
    logic       w_act;
    logic       w_tail;
    logic       w_star;
    logic       w_hit;
    logic       w_raw;

    assign w_act  = IDX_L < i_len;
    assign w_tail = IDX_L == i_len;
    assign w_star = r_ch == STAR_CHAR;
    assign w_hit  = (r_ch == QUERY_CHAR) || (fold_byte(r_ch, i_ctl.mode) == i_ctl.ch_fold);

    // A star keeps its own position; any other byte hands the live bit on when it hits.
    assign w_raw  = (w_act && r_live && w_star) || i_step;
    assign o_step = i_ctl.str_step && w_act && r_live && !w_star && w_hit;

    // Skip over a star: stars never sit next to each other, so one hop suffices.
    always_comb begin
        if (i_ctl.str_step) begin
            o_fwd = w_raw && w_act && w_star;
        end else if (i_ctl.end_str) begin
            o_fwd = (IDX == 0) && w_act && w_star;
        end else begin
            o_fwd = i_ctl.app_wr && w_tail && r_live && (i_ctl.ch == STAR_CHAR);
        end
    end

    always_comb begin
        n_live = r_live;
        n_ch   = r_ch;
        if (i_ctl.restart) begin
            n_live = (IDX == 0) || i_fwd;
        end else if (i_ctl.str_step) begin
            n_live = w_raw || i_fwd;
        end else if (i_ctl.app_wr) begin
            n_live = r_live || i_fwd;
            if (w_tail) begin
                n_ch = i_ctl.ch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= (IDX == 0);
        end else begin
            r_live <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch <= n_ch;
    end

    assign o_live = r_live;

endmodule

// ===== design/wildcard_glob_matcher_unit.sv =====
// Glob matcher top level: request/response handling, mask length and overflow
// bookkeeping, and the chain of wgm_cell positions. Depends on wgm_pkg, wgm_if, wgm_cell.
//
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   operation[1:0], ch[7:0]
//  o_rsp     out  valid/ready   matched, mask_overflow
//  i_cfg_*   in   write enable  case_mode[1:0]
//
// One transaction is accepted each cycle while the response
// register is empty or being drained. End of string answers in the
// next cycle from the live bit at the tail. The chain of MAX_MASK+1 cells
// updates all positions in parallel. Runs of stars are stored as one star.
// Reset is synchronous; i_req.ready drops only while a response is stalled.
module wildcard_glob_matcher_unit #(
    parameter int MAX_MASK = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    wgm_req_if.sink     i_req,
    wgm_rsp_if.source   o_rsp
);
    import wgm_pkg::*;

    localparam int NCELL = MAX_MASK + 1;
    localparam int LEN_W = $clog2(NCELL);

    logic [1:0]       r_case_mode;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] r_count;
    logic [LEN_W-1:0] n_count;
    logic             r_last_star;
    logic             n_last_star;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_out_matched;
    logic             r_out_ovf;

    logic             w_fire;
    logic             w_full;
    logic             w_collapse;
    logic             w_is_star;
    t_cell_ctl        w_ctl;
    logic [NCELL-1:0] w_live;
    logic [NCELL-1:0] w_step;
    logic [NCELL-1:0] w_fwd;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_full      = r_count == LEN_W'(MAX_MASK);
    assign w_is_star   = i_req.ch == STAR_CHAR;
    assign w_collapse  = w_is_star && r_last_star;

    always_comb begin
        w_ctl.str_step = w_fire && (i_req.operation == OP_STRING);
        w_ctl.app_wr   = w_fire && (i_req.operation == OP_APPEND) && !w_full && !w_collapse;
        w_ctl.restart  = w_fire && (i_req.operation == OP_CLEAR || i_req.operation == OP_END);
        w_ctl.end_str  = w_fire && (i_req.operation == OP_END);
        w_ctl.ch       = i_req.ch;
        w_ctl.ch_fold  = fold_byte(i_req.ch, r_case_mode);
        w_ctl.mode     = r_case_mode;
    end

    assign w_step[0] = 1'b0;
    assign w_fwd[0]  = 1'b0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        if (k < NCELL - 1) begin : g_mid
            wgm_cell #(.IDX(k), .LEN_W(LEN_W)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl),
                .i_len  (r_len),
                .i_step (w_step[k]),
                .i_fwd  (w_fwd[k]),
                .o_step (w_step[k+1]),
                .o_fwd  (w_fwd[k+1]),
                .o_live (w_live[k])
            );
        end else begin : g_last
            wgm_cell #(.IDX(k), .LEN_W(LEN_W)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl),
                .i_len  (r_len),
                .i_step (w_step[k]),
                .i_fwd  (w_fwd[k]),
                .o_step (),
                .o_fwd  (),
                .o_live (w_live[k])
            );
        end
    end

    always_comb begin
        n_len       = r_len;
        n_count     = r_count;
        n_last_star = r_last_star;
        n_ovf       = r_ovf;
        if (w_fire) begin
            case (i_req.operation)
                OP_CLEAR: begin
                    n_len       = '0;
                    n_count     = '0;
                    n_last_star = 1'b0;
                    n_ovf       = 1'b0;
                end
                OP_APPEND: begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        // drop a star that follows a star: same language, one cell fewer
                        if (!w_collapse) begin
                            n_len       = r_len + 1'b1;
                            n_last_star = w_is_star;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_fire && i_req.operation == OP_END) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_mode <= 2'd0;
            r_len       <= '0;
            r_count     <= '0;
            r_last_star <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_case_mode <= i_cfg_wdata;
            end
            r_len       <= n_len;
            r_count     <= n_count;
            r_last_star <= n_last_star;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_req.operation == OP_END) begin
            r_out_matched <= w_live[r_len] && !r_ovf;
            r_out_ovf     <= r_ovf;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.matched       = r_out_matched;
    assign o_rsp.mask_overflow = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_len_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= r_count)
        else $error("stored mask length exceeds append count");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == LEN_W'(MAX_MASK))
        else $error("overflow flag set while mask not full");

    a_end_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_req.operation == OP_END |=> r_out_valid)
        else $error("end of string did not produce a response");

    a_restart_pos0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.restart |=> w_live[0])
        else $error("position zero not live after restart");

    a_match_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_matched |-> !r_out_ovf)
        else $error("match reported together with overflow");
`endif

endmodule
